// ----- hw/rtl/wcc_pkg.sv -----
// Package for the wall-clock tick catch-up block: payload structs, FSM states,
// calendar tables and arithmetic constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wcc_pkg;

   localparam int unsigned TICK_RATE_W = 10;
   localparam int unsigned SECS_W      = 39;
   localparam int unsigned NANOS_W     = 30;
   localparam int unsigned DELTA_W     = 33;
   localparam int unsigned PROD_W      = DELTA_W + TICK_RATE_W;
   localparam int unsigned QUOT_W      = 35;
   localparam int unsigned REM_W       = 30;
   localparam int unsigned EST_LSB     = 20;
   localparam int unsigned EST_W       = PROD_W - EST_LSB;
   localparam int unsigned RECIP_W     = 15;
   localparam int unsigned EST_PROD_W  = EST_W + RECIP_W;
   localparam int unsigned QEST_LSB    = 24;
   localparam int unsigned QEST_W      = 14;

   localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 10'd100;
   localparam logic [REM_W-1:0]       NS_PER_SEC      = 30'd1000000000;
   localparam logic [DELTA_W-1:0]     MAX_CATCHUP_NS  = 33'd5000000000;
   localparam logic [7:0]             MAX_TICKS       = 8'd150;
   localparam logic [15:0]            YEAR_MIN        = 16'd1900;
   localparam logic [15:0]            YEAR_MAX        = 16'd9999;
   localparam logic [12:0]            RECIP_100       = 13'd5243;
   // floor(2^44 / 1e9): quotient estimate never above the true quotient
   localparam logic [RECIP_W-1:0]     RECIP_NS        = 15'd17592;
   // 2^64 split as quotient and remainder of one billion
   localparam logic [QUOT_W-1:0]      WRAP_Q          = 35'd18446744073;
   localparam logic [REM_W-1:0]       WRAP_R          = 30'd709551616;
   localparam int unsigned            QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic        sample_ok;
      logic [15:0] wall_year;
      logic [7:0]  wall_month;
      logic [7:0]  wall_day;
      logic [7:0]  wall_hour;
      logic [7:0]  wall_minute;
      logic [7:0]  wall_second;
      logic [31:0] wall_nanos;
   } req_type;

   typedef struct packed {
      logic [7:0] run_ticks;
      logic       sample_used;
   } rsp_type;

   typedef struct packed {
      logic               ok;
      logic [SECS_W-1:0]  secs;
      logic [NANOS_W-1:0] nanos;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [2:0] {
      F_IDLE, F_YEAR, F_CHECK, F_DAYS, F_HOURS, F_MINS, F_SECS, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_DELTA, B_SCALE, B_EST, B_FIX, B_NORM, B_ACCUM, B_WRAP, B_LAG, B_OUT
   } back_state_type;

   // Days in month (1..12); other codes give 0
   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
      logic [4:0] d;
      case (mo)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

   // Days before the first of a month in a common year
   function automatic logic [8:0] cum_days(input logic [3:0] mo);
      logic [8:0] d;
      case (mo)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wcc_front.sv -----
// Front end: accepts wall-clock samples, validates the calendar date and
// converts it to seconds since year 1 in a short sequencer. Uses wcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wcc_front
   import wcc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   input  wire q_status_type q_stat,
   output logic              q_push,
   output entry_type         q_wdata
);

   front_state_type state_ff, state_in;

   req_type                  sample_ff;
   logic [28:0]              yq_ff, yrq_ff;
   logic                     ok_ff, ok_in;
   logic                     leap_ff, leap_in;
   logic [21:0]              days_ff;
   logic [26:0]              hrs_ff;
   logic [32:0]              mins_ff;
   logic [SECS_W-1:0]        secs_ff;

   logic [15:0] yrs;
   logic [9:0]  q100, qy100;
   logic [15:0] r100;
   logic [3:0]  mo4;
   logic [21:0] days_in;

   assign yrs   = sample_ff.wall_year - 16'd1;
   assign q100  = yq_ff[28:19];
   assign qy100 = yrq_ff[28:19];
   assign r100  = sample_ff.wall_year - 16'(17'(q100) * 17'd100);
   assign mo4   = sample_ff.wall_month[3:0];

   // Leap year and range checks
   always_comb begin
      leap_in = ((sample_ff.wall_year[1:0] == 2'd0) && (r100 != 16'd0)) ||
                ((r100 == 16'd0) && (q100[1:0] == 2'd0));
      ok_in   = sample_ff.sample_ok &&
                (sample_ff.wall_year >= YEAR_MIN) && (sample_ff.wall_year <= YEAR_MAX) &&
                (sample_ff.wall_month >= 8'd1) && (sample_ff.wall_month <= 8'd12) &&
                (sample_ff.wall_day >= 8'd1) &&
                (sample_ff.wall_day <= 8'(month_days(mo4, leap_in))) &&
                (sample_ff.wall_hour <= 8'd23) && (sample_ff.wall_minute <= 8'd59) &&
                (sample_ff.wall_second <= 8'd59) &&
                (sample_ff.wall_nanos < 32'(NS_PER_SEC));
   end

   // Day count from year, month and day
   assign days_in = 22'(yrs) * 22'd365 + 22'(yrs >> 2) - 22'(qy100) + 22'(qy100 >> 2) +
                    22'(cum_days(mo4)) +
                    22'(leap_ff && (sample_ff.wall_month > 8'd2)) +
                    22'(sample_ff.wall_day - 8'd1);

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the sample and the partial results
   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE:  if (req_valid) sample_ff <= req_data;
         F_YEAR: begin
            yq_ff  <= 29'(sample_ff.wall_year) * 29'(RECIP_100);
            yrq_ff <= 29'(yrs) * 29'(RECIP_100);
         end
         F_CHECK: begin
            ok_ff   <= ok_in;
            leap_ff <= leap_in;
         end
         F_DAYS:  days_ff <= days_in;
         F_HOURS: hrs_ff  <= 27'(days_ff) * 27'd24 + 27'(sample_ff.wall_hour);
         F_MINS:  mins_ff <= 33'(hrs_ff) * 33'd60 + 33'(sample_ff.wall_minute);
         F_SECS:  secs_ff <= SECS_W'(mins_ff) * SECS_W'(60) + SECS_W'(sample_ff.wall_second);
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (req_valid) state_in = F_YEAR;
         F_YEAR:  state_in = F_CHECK;
         F_CHECK: state_in = ok_in ? F_DAYS : F_PUSH;
         F_DAYS:  state_in = F_HOURS;
         F_HOURS: state_in = F_MINS;
         F_MINS:  state_in = F_SECS;
         F_SECS:  state_in = F_PUSH;
         F_PUSH:  if (!q_stat.full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = (state_ff == F_IDLE);
      q_push        = (state_ff == F_PUSH) && !q_stat.full;
      q_wdata.ok    = ok_ff;
      q_wdata.secs  = secs_ff;
      q_wdata.nanos = sample_ff.wall_nanos[NANOS_W-1:0];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/wcc_queue.sv -----
// Short FIFO of converted samples between front and back end.
// Uses wcc_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module wcc_queue
   import wcc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type wdata,
   input  wire logic      pop,
   output entry_type      rdata,
   output q_status_type   status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   assign rdata        = mem_ff[rd_ptr_ff];
   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ----- hw/rtl/wcc_back.sv -----
// Back end: measures the wall advance, scales it by the tick rate, splits it
// by one billion with a reciprocal estimate and one correction, keeps the
// accumulator as quotient and remainder, and emits the ticks due. Uses wcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wcc_back
   import wcc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [TICK_RATE_W-1:0] tick_rate,
   input  wire q_status_type           q_stat,
   input  wire entry_type              q_rdata,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data
);

   back_state_type state_ff, state_in;

   entry_type            ent_ff;
   logic [SECS_W-1:0]    last_secs_ff;
   logic [NANOS_W-1:0]   last_ns_ff;
   logic                 have_ff;
   logic [DELTA_W-1:0]   delta_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [QEST_W-1:0]    qest_ff;
   logic [REM_W:0]       part_ff;
   logic [QEST_W-1:0]    pq_ff;
   logic [REM_W-1:0]     pr_ff;
   logic [QUOT_W-1:0]    accq_ff;
   logic [REM_W-1:0]     accr_ff;
   logic [7:0]           due_ff;
   logic                 used_ff;
   logic [63:0]          lc_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                  fwd;
   logic [SECS_W-1:0]     sd;
   logic [DELTA_W:0]      raw;
   logic [DELTA_W-1:0]    delta_in;
   logic [EST_PROD_W-1:0] est_prod;
   logic [PROD_W-1:0]     part_full;
   logic                  part_ge;
   logic [REM_W:0]        r_sum;
   logic                  carry;
   logic                  wrap;
   logic [63:0]           target, lag;
   logic [7:0]            due_in;
   logic                  out_free;

   // Advance since the last recorded sample, clamped
   always_comb begin
      fwd = have_ff && ((ent_ff.secs > last_secs_ff) ||
                        ((ent_ff.secs == last_secs_ff) && (ent_ff.nanos >= last_ns_ff)));
      sd  = ent_ff.secs - last_secs_ff;
      raw = (DELTA_W+1)'(sd[2:0]) * (DELTA_W+1)'(NS_PER_SEC) +
            (DELTA_W+1)'(ent_ff.nanos) - (DELTA_W+1)'(last_ns_ff);
      if (!fwd) begin
         delta_in = '0;
      end else if (sd > SECS_W'(5) || raw > (DELTA_W+1)'(MAX_CATCHUP_NS)) begin
         delta_in = MAX_CATCHUP_NS;
      end else begin
         delta_in = raw[DELTA_W-1:0];
      end
   end

   // Split the scaled advance by one billion, add to the accumulator, clamp the lag
   always_comb begin
      est_prod  = EST_PROD_W'(prod_ff[PROD_W-1:EST_LSB]) * EST_PROD_W'(RECIP_NS);
      part_full = prod_ff - PROD_W'(qest_ff) * PROD_W'(NS_PER_SEC);
      part_ge   = part_ff >= (REM_W+1)'(NS_PER_SEC);
      r_sum     = (REM_W+1)'(accr_ff) + (REM_W+1)'(pr_ff);
      carry     = r_sum >= (REM_W+1)'(NS_PER_SEC);
      wrap      = (accq_ff > WRAP_Q) || ((accq_ff == WRAP_Q) && (accr_ff >= WRAP_R));
      target    = 64'(accq_ff);
      lag       = target - lc_ff;
      if (target <= lc_ff) begin
         due_in = 8'd1;
      end else if (lag > 64'(MAX_TICKS)) begin
         due_in = MAX_TICKS;
      end else begin
         due_in = lag[7:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state: history, accumulator, logical count, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         last_secs_ff <= '0;
         last_ns_ff   <= '0;
         have_ff      <= 1'b0;
         accq_ff      <= '0;
         accr_ff      <= '0;
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_DELTA && ent_ff.ok) begin
            last_secs_ff <= ent_ff.secs;
            last_ns_ff   <= ent_ff.nanos;
            have_ff      <= 1'b1;
         end
         // Add quotient and remainder with carry
         if (state_ff == B_ACCUM) begin
            accr_ff <= carry ? REM_W'(r_sum - (REM_W+1)'(NS_PER_SEC)) : r_sum[REM_W-1:0];
            accq_ff <= accq_ff + QUOT_W'(pq_ff) + QUOT_W'(carry);
         end
         // Wrap the accumulator modulo 2^64
         if (state_ff == B_WRAP && wrap) begin
            if (accr_ff >= WRAP_R) begin
               accr_ff <= accr_ff - WRAP_R;
               accq_ff <= accq_ff - WRAP_Q;
            end else begin
               accr_ff <= accr_ff + (NS_PER_SEC - WRAP_R);
               accq_ff <= accq_ff - WRAP_Q - QUOT_W'(1);
            end
         end
         if (state_ff == B_OUT && out_free) begin
            lc_ff        <= lc_ff + 64'(due_ff);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE:  if (!q_stat.empty) ent_ff <= q_rdata;
         B_DELTA: begin
            delta_ff <= delta_in;
            due_ff   <= 8'd1;
            used_ff  <= 1'b0;
         end
         B_SCALE: prod_ff <= PROD_W'(delta_ff) * PROD_W'(tick_rate);
         B_EST:   qest_ff <= est_prod[QEST_LSB +: QEST_W];
         B_FIX:   part_ff <= part_full[REM_W:0];
         B_NORM: begin
            pq_ff <= part_ge ? qest_ff + QEST_W'(1) : qest_ff;
            pr_ff <= part_ge ? REM_W'(part_ff - (REM_W+1)'(NS_PER_SEC)) : part_ff[REM_W-1:0];
         end
         B_LAG: begin
            due_ff  <= due_in;
            used_ff <= 1'b1;
         end
         B_OUT: if (out_free) begin
            rsp_data_ff.run_ticks   <= due_ff;
            rsp_data_ff.sample_used <= used_ff;
         end
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!q_stat.empty) state_in = B_DELTA;
         B_DELTA: state_in = ent_ff.ok ? B_SCALE : B_OUT;
         B_SCALE: state_in = B_EST;
         B_EST:   state_in = B_FIX;
         B_FIX:   state_in = B_NORM;
         B_NORM:  state_in = B_ACCUM;
         B_ACCUM: state_in = B_WRAP;
         B_WRAP:  state_in = B_LAG;
         B_LAG:   state_in = B_OUT;
         B_OUT:   if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      q_pop     = (state_ff == B_IDLE) && !q_stat.empty;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/wall_clock_tick_catch_up.sv -----
// Wall-clock tick catch-up, top level. A valid sample passes the front-end date
// conversion (year, check, days, hours, minutes, seconds, push), the queue and
// the back-end sequencer; a rejected sample skips the arithmetic steps in both.
// Each end takes one sample at a time; throughput is set by the back-end sequencer,
// the longer of the two; a stalled response backs up through the queue.
// Synchronous active-high reset clears control state; tick rate returns to 100.
`timescale 1ns / 1ps
`default_nettype none

module wall_clock_tick_catch_up
   import wcc_pkg::*;
#(
   parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [TICK_RATE_W-1:0] csr_wr_data
);

   logic [TICK_RATE_W-1:0] tick_rate_ff;
   q_status_type           q_stat;
   logic                   q_push, q_pop;
   entry_type              q_wdata, q_rdata;

   // Hold the tick rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else if (csr_wr_en) begin
         tick_rate_ff <= csr_wr_data;
      end
   end

   wcc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_stat, .q_push, .q_wdata
   );

   wcc_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .push(q_push), .wdata(q_wdata), .pop(q_pop),
      .rdata(q_rdata), .status(q_stat)
   );

   wcc_back u_back (
      .clock, .reset, .tick_rate(tick_rate_ff), .q_stat, .q_rdata, .q_pop,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   // Ticks due always within 1..150
   a_due_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.run_ticks != 8'd0) && (rsp_data.run_ticks <= MAX_TICKS))
      else $error("run_ticks out of range");

   // A rejected sample runs exactly one tick
   a_unused_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.sample_used) |-> (rsp_data.run_ticks == 8'd1))
      else $error("unused sample with run_ticks not one");

   // Queue never pushed when full nor popped when empty
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
      else $error("queue overflow or underflow");

   // A new response only loads after the previous one is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");

endmodule

`default_nettype wire
